[rtl/compacting_verdict_queue_macros.svh]
// assertion macros for the verdict queue
`ifndef COMPACTING_VERDICT_QUEUE_MACROS_SVH
`define COMPACTING_VERDICT_QUEUE_MACROS_SVH

// checked on every clock, quiet while reset is asserted
`define CVQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked on every clock, reset included
`define CVQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/cvq_pkg.sv]
// shared constants and types of the verdict queue
`timescale 1ns / 1ps
`default_nettype none
package cvq_pkg;

  localparam int DEPTH  = 64;
  localparam int TIME_W = 31;
  localparam int WORD_W = TIME_W + 1;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int LEN_W  = $clog2(DEPTH + 1);

  localparam logic [WORD_W-1:0] EMPTY_WORD = {WORD_W{1'b1}};

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RD    = 4'b0010,
    ST_WEVAL = 4'b0100,
    ST_SCAN  = 4'b1000
  } state_t;

  // length register clamped to 1..DEPTH
  function automatic len_t eff_len(input len_t raw);
    len_t res;
    if (raw == '0) begin
      res = len_t'(1);
    end else if (raw > len_t'(DEPTH)) begin
      res = len_t'(DEPTH);
    end else begin
      res = raw;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

[rtl/compacting_verdict_queue.sv]
// top level of the compacting verdict queue
`timescale 1ns / 1ps
`default_nettype none
`include "compacting_verdict_queue_macros.svh"
// Usage
//   request channel: start/busy. A request is taken at a clock edge with start high
//   and busy low. in_operation selects write (store in_entry_value) or check
//   (scan from in_read_index for a time at least in_wanted_time).
//   result channel: out_valid is high for exactly one cycle per request with
//   out_found, out_found_entry and out_next_read_index. The receiver cannot stall,
//   so the result is simply dropped onto the ports the cycle after it is computed.
//   config channel: cfg_valid/cfg_ready carries the queue length; cfg_ready is
//   always high, writes are only expected while the block is idle.
// Sequence
//   write: ST_RD reads the prev and current slots on the two read ports, then
//   ST_WEVAL does one compare and write-back.
//   check: ST_RD reads the entry under the reader, then ST_SCAN visits 1..length
//   entries; the scan reads one entry per cycle on memory read port a.
//   a new request can be taken in the cycle the result strobe is shown.
// Reset
//   pointer to zero, length to 64; a per-entry valid flop array is cleared, so
//   every slot reads as the all-ones empty word without a clearing pass.
module compacting_verdict_queue (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      start,
  output logic                     busy,
  input  wire                      in_operation,
  input  wire  [31:0]              in_entry_value,
  input  wire  [5:0]               in_read_index,
  input  wire  [30:0]              in_wanted_time,
  output logic                     out_valid,
  output logic                     out_found,
  output logic [31:0]              out_found_entry,
  output logic [5:0]               out_next_read_index,
  input  wire                      cfg_valid,
  output logic                     cfg_ready,
  input  wire  [6:0]               cfg_data
);

  // control state
  cvq_pkg::state_t state_r, state_nxt;
  cvq_pkg::len_t   qlen_r;
  cvq_pkg::len_t   len_r, len_nxt;
  cvq_pkg::idx_t   wp_r, wp_nxt;
  cvq_pkg::idx_t   rd_r, rd_nxt;
  logic            first_r, first_nxt;
  logic            out_valid_r, out_valid_nxt;

  // request payload
  logic                          op_r, op_nxt;
  cvq_pkg::word_t                word_r, word_nxt;
  logic [cvq_pkg::TIME_W-1:0]    want_r, want_nxt;

  // result payload
  logic            found_r, found_nxt;
  cvq_pkg::word_t  entry_r, entry_nxt;
  cvq_pkg::idx_t   nri_r, nri_nxt;

  // verdict store, two registered read ports, one write port
  cvq_pkg::word_t  mem [cvq_pkg::DEPTH];
  logic [cvq_pkg::DEPTH-1:0] valid_r;
  cvq_pkg::word_t  rdata_a_r, rdata_b_r;
  logic            rvalid_a_r, rvalid_b_r;
  cvq_pkg::idx_t   addr_a, addr_b, waddr;
  cvq_pkg::word_t  wdata;
  logic            mem_we;
  cvq_pkg::word_t  data_a, data_b;

  // helpers
  cvq_pkg::len_t   acc_len;
  cvq_pkg::idx_t   acc_wp;
  cvq_pkg::idx_t   prev_idx;
  cvq_pkg::idx_t   scan_next;
  cvq_pkg::idx_t   slot;
  cvq_pkg::len_t   slot_inc;
  logic            compact;

  assign busy                = (state_r != cvq_pkg::ST_IDLE);
  assign cfg_ready           = 1'b1;
  assign out_valid           = out_valid_r;
  assign out_found           = found_r;
  assign out_found_entry     = entry_r;
  assign out_next_read_index = nri_r;

  // empty slots read as all ones
  assign data_a = rvalid_a_r ? rdata_a_r : cvq_pkg::EMPTY_WORD;
  assign data_b = rvalid_b_r ? rdata_b_r : cvq_pkg::EMPTY_WORD;

  // clamped length and pointer for the request being taken
  assign acc_len = cvq_pkg::eff_len(qlen_r);
  assign acc_wp  = ({1'b0, wp_r} >= acc_len) ? '0 : wp_r;

  // slot before the write pointer, wrapping at the length
  assign prev_idx = (wp_r == '0) ? cvq_pkg::idx_t'(len_r - cvq_pkg::len_t'(1))
                                 : wp_r - cvq_pkg::idx_t'(1);

  // next scan position, wrapping at the length
  assign scan_next = ({1'b0, rd_r} + cvq_pkg::len_t'(1) == len_r) ? '0
                                                                   : rd_r + cvq_pkg::idx_t'(1);

  // compaction onto the previous slot
  assign compact = (data_a[cvq_pkg::WORD_W-1] == word_r[cvq_pkg::WORD_W-1]) &&
                   (data_a != data_b) && (data_b != cvq_pkg::EMPTY_WORD);
  assign slot     = compact ? prev_idx : wp_r;
  assign slot_inc = {1'b0, slot} + cvq_pkg::len_t'(1);

  // read addresses: prev/current for writes, scan pointer for checks
  always_comb begin
    addr_a = rd_r;
    addr_b = wp_r;
    if (state_r == cvq_pkg::ST_RD) begin
      addr_a = (op_r == cvq_pkg::OP_CHECK) ? rd_r : prev_idx;
    end else if (state_r == cvq_pkg::ST_SCAN) begin
      addr_a = scan_next;
    end
  end

  assign mem_we = (state_r == cvq_pkg::ST_WEVAL);
  assign waddr  = slot;
  assign wdata  = word_r;

  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    wp_nxt        = wp_r;
    rd_nxt        = rd_r;
    first_nxt     = first_r;
    op_nxt        = op_r;
    word_nxt      = word_r;
    want_nxt      = want_r;
    found_nxt     = found_r;
    entry_nxt     = entry_r;
    nri_nxt       = nri_r;
    out_valid_nxt = 1'b0;
    case (state_r)
      cvq_pkg::ST_IDLE: begin
        if (start) begin
          op_nxt    = in_operation;
          word_nxt  = in_entry_value;
          want_nxt  = in_wanted_time;
          len_nxt   = acc_len;
          wp_nxt    = acc_wp;
          first_nxt = 1'b1;
          // checks clamp the reader pointer, writes echo it unchanged
          if (in_operation == cvq_pkg::OP_CHECK && {1'b0, in_read_index} >= acc_len) begin
            rd_nxt = '0;
          end else begin
            rd_nxt = in_read_index;
          end
          state_nxt = cvq_pkg::ST_RD;
        end
      end
      cvq_pkg::ST_RD: begin
        state_nxt = (op_r == cvq_pkg::OP_CHECK) ? cvq_pkg::ST_SCAN : cvq_pkg::ST_WEVAL;
      end
      cvq_pkg::ST_WEVAL: begin
        wp_nxt        = (slot_inc == len_r) ? '0 : slot;
        if (slot_inc != len_r) begin
          wp_nxt = cvq_pkg::idx_t'(slot_inc);
        end
        found_nxt     = 1'b0;
        entry_nxt     = '0;
        nri_nxt       = rd_r;
        out_valid_nxt = 1'b1;
        state_nxt     = cvq_pkg::ST_IDLE;
      end
      cvq_pkg::ST_SCAN: begin
        first_nxt = 1'b0;
        if (first_r && data_a == cvq_pkg::EMPTY_WORD) begin
          // nothing stored under the reader
          found_nxt     = 1'b0;
          entry_nxt     = '0;
          nri_nxt       = rd_r;
          out_valid_nxt = 1'b1;
          state_nxt     = cvq_pkg::ST_IDLE;
        end else if (data_a[cvq_pkg::TIME_W-1:0] >= want_r) begin
          found_nxt     = 1'b1;
          entry_nxt     = data_a;
          nri_nxt       = rd_r;
          out_valid_nxt = 1'b1;
          state_nxt     = cvq_pkg::ST_IDLE;
        end else if (scan_next == wp_r) begin
          // hit the writer, step back one slot: that is the current position
          found_nxt     = 1'b0;
          entry_nxt     = '0;
          nri_nxt       = rd_r;
          out_valid_nxt = 1'b1;
          state_nxt     = cvq_pkg::ST_IDLE;
        end else begin
          rd_nxt = scan_next;
        end
      end
      default: begin
        state_nxt = cvq_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cvq_pkg::ST_IDLE;
      qlen_r      <= cvq_pkg::len_t'(cvq_pkg::DEPTH);
      len_r       <= cvq_pkg::len_t'(cvq_pkg::DEPTH);
      wp_r        <= '0;
      rd_r        <= '0;
      first_r     <= 1'b0;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      wp_r        <= wp_nxt;
      rd_r        <= rd_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        qlen_r <= cfg_data;
      end
      if (mem_we) begin
        valid_r[waddr] <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    word_r  <= word_nxt;
    want_r  <= want_nxt;
    found_r <= found_nxt;
    entry_r <= entry_nxt;
    nri_r   <= nri_nxt;
  end

  // store and its registered reads
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata_a_r  <= mem[addr_a];
    rdata_b_r  <= mem[addr_b];
    rvalid_a_r <= valid_r[addr_a];
    rvalid_b_r <= valid_r[addr_b];
  end

  // checks
  `CVQ_ASSERT(a_strobe_from_eval,
    out_valid |-> ($past(state_r) == cvq_pkg::ST_WEVAL || $past(state_r) == cvq_pkg::ST_SCAN),
    "result strobe without a finished request")
  `CVQ_ASSERT(a_single_strobe, out_valid |-> !$past(out_valid),
    "result strobe longer than one cycle")
  `CVQ_ASSERT(a_found_only_check, (out_valid && out_found) |-> (op_r == cvq_pkg::OP_CHECK),
    "found reported for a write")
  `CVQ_ASSERT(a_scan_in_range, (state_r == cvq_pkg::ST_SCAN) |-> ({1'b0, rd_r} < len_r),
    "scan pointer beyond queue length")

endmodule
`default_nettype wire
